FILE: sv/bucket_slot_reservation_counter_assert.svh
// Assertion macros for the bucket slot reservation counter.
// Depends on aclk and aresetn being visible where the macros are used.
`ifndef BUCKET_SLOT_RESERVATION_COUNTER_ASSERT_SVH
`define BUCKET_SLOT_RESERVATION_COUNTER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BSRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BSRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bsrc_pkg.sv
// Shared constants, codes and types of the bucket slot reservation counter.
// No dependencies.
package bsrc_pkg;

    localparam int MAX_CATEGORIES = 1024;
    localparam int MAX_CAPACITY   = 4096;

    localparam int CAT_W  = $clog2(MAX_CATEGORIES);
    localparam int NCAT_W = 11;
    localparam int CNT_W  = 13;
    localparam int SUM_W  = 23;
    localparam int PROC_W = 32;
    localparam int ADDR_W = 22;
    localparam int MUL_W  = CAT_W + CNT_W;

    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TUSER_W = 4;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_USED_W  = ADDR_W + 3 * SUM_W + PROC_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    localparam logic [CNT_W-1:0]  RST_BACKING = CNT_W'(4096);
    localparam logic [CNT_W-1:0]  RST_CACHE   = CNT_W'(256);
    localparam logic [NCAT_W-1:0] RST_NCAT    = NCAT_W'(1024);

    localparam logic [1:0] REG_BACKING = 2'd0;
    localparam logic [1:0] REG_CACHE   = 2'd1;
    localparam logic [1:0] REG_NCAT    = 2'd2;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_UNDO  = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_ROOM        = 3'd0,
        ST_LAST        = 3'd1,
        ST_CACHE_FULL  = 3'd2,
        ST_CAT_FULL    = 3'd3,
        ST_UNDO_EMPTY  = 3'd4,
        ST_BAD_CAT     = 3'd5
    } status_t;

    typedef struct packed {
        logic [CNT_W-1:0]  eff_backing;
        logic [CNT_W-1:0]  eff_cache;
        logic [NCAT_W-1:0] eff_ncat;
    } cfg_t;

endpackage

FILE: sv/bsrc_apb_regs.sv
// Configuration registers behind the APB port, with clipped effective values.
// Depends on bsrc_pkg.
module bsrc_apb_regs
    import bsrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [CNT_W-1:0]  bcap_reg, bcap_next;
    logic [CNT_W-1:0]  ccap_reg, ccap_next;
    logic [NCAT_W-1:0] ncat_reg, ncat_next;
    logic              wr_en;
    logic [CNT_W-1:0]  eff_b;
    logic [CNT_W-1:0]  eff_c;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        bcap_next = bcap_reg;
        ccap_next = ccap_reg;
        ncat_next = ncat_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_BACKING: bcap_next = pwdata[CNT_W-1:0];
                REG_CACHE:   ccap_next = pwdata[CNT_W-1:0];
                REG_NCAT:    ncat_next = pwdata[NCAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcap_reg <= RST_BACKING;
            ccap_reg <= RST_CACHE;
            ncat_reg <= RST_NCAT;
        end else begin
            bcap_reg <= bcap_next;
            ccap_reg <= ccap_next;
            ncat_reg <= ncat_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BACKING: prdata = PDATA_W'(bcap_reg);
            REG_CACHE:   prdata = PDATA_W'(ccap_reg);
            REG_NCAT:    prdata = PDATA_W'(ncat_reg);
            default:     prdata = '0;
        endcase
    end

    // Clip capacities; a zero cache capacity counts as one slot.
    always_comb begin
        eff_b = (bcap_reg > CNT_W'(MAX_CAPACITY)) ? CNT_W'(MAX_CAPACITY) : bcap_reg;
        eff_c = (ccap_reg > eff_b) ? eff_b : ccap_reg;
        if (eff_c == '0) begin
            eff_c = CNT_W'(1);
        end
        cfg.eff_backing = eff_b;
        cfg.eff_cache   = eff_c;
        cfg.eff_ncat    = (ncat_reg > NCAT_W'(MAX_CATEGORIES)) ?
                          NCAT_W'(MAX_CATEGORIES) : ncat_reg;
    end

endmodule

FILE: sv/bucket_slot_reservation_counter.sv
// Top level of the bucket slot reservation counter: request FSM and count memory.
// Depends on bsrc_pkg, bsrc_apb_regs and bucket_slot_reservation_counter_assert.svh.
//
// Usage:
//   s_ channel carries one request: s_tuser is the request type (add, undo,
//   flush, no operation), s_tdata the category. m_ channel returns one result
//   per request: m_tuser holds status and slot-valid, m_tdata the reserved slot
//   address and the cached, written, added and processed totals.
//   Add, undo and no operation first read the category's cache and backing
//   counts from the count memory, then update them and write back any count
//   that changes. Flush walks all 1024 categories through the same memory at
//   one entry per cycle.
//   After reset a clearing pass zeroes all 1024 count memory entries;
//   s_tready stays low during it, configuration writes are taken as usual.
//   The result sits in an output register; the next request is accepted while
//   it waits, but finishes only once the receiver has taken the previous one.
//   Configuration goes through the APB port: backing capacity at 0x0, cache
//   capacity at 0x4, categories in use at 0x8.
`include "bucket_slot_reservation_counter_assert.svh"

module bucket_slot_reservation_counter
    import bsrc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] category, rest zero
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // [1:0] req_type
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [21:0] slot_address, [44:22] cached_total, [67:45] written_total,
    // [90:68] added_total, [122:91] processed_total, rest zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser,   // [2:0] status, [3] slot_valid
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FLUSH
    } state_t;

    cfg_t cfg;

    bsrc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Count memory: each entry is {backing count, cache count}.
    logic [2*CNT_W-1:0] cnt_mem [MAX_CATEGORIES];
    logic [2*CNT_W-1:0] rdata_reg;
    logic               mem_we;
    logic               mem_re;
    logic [CAT_W-1:0]   mem_waddr;
    logic [CAT_W-1:0]   mem_raddr;
    logic [2*CNT_W-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= cnt_mem[mem_raddr];
        end
    end

    state_t                  state_reg, state_next;
    logic [CAT_W:0]          idx_reg, idx_next;
    logic                    wb_vld_reg, wb_vld_next;
    logic [CAT_W-1:0]        wb_idx_reg, wb_idx_next;
    logic [1:0]              req_reg, req_next;
    logic [CAT_W-1:0]        cat_reg, cat_next;
    logic [SUM_W-1:0]        cached_reg, cached_next;
    logic [SUM_W-1:0]        written_reg, written_next;
    logic [SUM_W-1:0]        added_reg, added_next;
    logic [PROC_W-1:0]       proc_reg, proc_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic               out_free;
    logic [CNT_W-1:0]   rd_cc;
    logic [CNT_W-1:0]   rd_bc;
    logic [CNT_W:0]     used;
    logic               good;
    logic [CNT_W-1:0]   cap_m1;
    logic [MUL_W-1:0]   prod;
    logic [MUL_W-1:0]   addr_sum;
    logic [CNT_W-1:0]   space;
    logic [CNT_W-1:0]   mv;
    status_t            status;
    logic               slot_vld;
    logic [ADDR_W-1:0]  slot_addr;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign rd_cc    = rdata_reg[CNT_W-1:0];
    assign rd_bc    = rdata_reg[2*CNT_W-1:CNT_W];
    assign used     = {1'b0, rd_cc} + {1'b0, rd_bc};
    assign good     = {1'b0, cat_reg} < cfg.eff_ncat;
    assign cap_m1   = cfg.eff_cache - CNT_W'(1);
    assign prod     = MUL_W'(cat_reg) * MUL_W'(cfg.eff_cache);
    assign addr_sum = prod + MUL_W'(rd_cc);
    assign space    = (rd_bc >= cfg.eff_backing) ? '0 : cfg.eff_backing - rd_bc;
    assign mv       = (rd_cc > space) ? space : rd_cc;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        wb_vld_next   = wb_vld_reg;
        wb_idx_next   = wb_idx_reg;
        req_next      = req_reg;
        cat_next      = cat_reg;
        cached_next   = cached_reg;
        written_next  = written_reg;
        added_next    = added_reg;
        proc_next     = proc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = '0;
        mem_raddr     = '0;
        mem_wdata     = '0;
        status        = ST_ROOM;
        slot_vld      = 1'b0;
        slot_addr     = '0;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[CAT_W-1:0];
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == (CAT_W+1)'(MAX_CATEGORIES - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    req_next = s_tuser;
                    cat_next = s_tdata[CAT_W-1:0];
                    if (s_tuser == REQ_FLUSH) begin
                        idx_next    = '0;
                        wb_vld_next = 1'b0;
                        state_next  = S_FLUSH;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = s_tdata[CAT_W-1:0];
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                if (out_free) begin
                    mem_waddr = cat_reg;
                    case (req_reg)
                        REQ_ADD: begin
                            proc_next = proc_reg + 1'b1;
                            if (!good) begin
                                status = ST_BAD_CAT;
                            end else if (used < {1'b0, cfg.eff_backing}) begin
                                if (rd_cc < cap_m1) begin
                                    status = ST_ROOM;
                                end else if (rd_cc == cap_m1) begin
                                    status = ST_LAST;
                                end else begin
                                    status = ST_CACHE_FULL;
                                end
                            end else begin
                                status = ST_CAT_FULL;
                            end
                            if (good && (status == ST_ROOM || status == ST_LAST)) begin
                                slot_vld    = 1'b1;
                                slot_addr   = addr_sum[ADDR_W-1:0];
                                mem_we      = 1'b1;
                                mem_wdata   = {rd_bc, rd_cc + 1'b1};
                                cached_next = cached_reg + 1'b1;
                                added_next  = added_reg + 1'b1;
                            end
                        end
                        REQ_UNDO: begin
                            if (!good) begin
                                status = ST_BAD_CAT;
                            end else if (rd_cc == '0) begin
                                status = ST_UNDO_EMPTY;
                            end else begin
                                mem_we      = 1'b1;
                                mem_wdata   = {rd_bc, rd_cc - 1'b1};
                                cached_next = cached_reg - 1'b1;
                                added_next  = added_reg - 1'b1;
                            end
                        end
                        default: status = ST_ROOM;
                    endcase
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = {slot_vld, status};
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, proc_next, added_next,
                                     written_next, cached_next, slot_addr};
                    state_next    = S_IDLE;
                end
            end

            S_FLUSH: begin
                // Read entry idx while writing back the entry read last cycle.
                if (idx_reg != (CAT_W+1)'(MAX_CATEGORIES)) begin
                    mem_re      = 1'b1;
                    mem_raddr   = idx_reg[CAT_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                    wb_vld_next = 1'b1;
                    wb_idx_next = idx_reg[CAT_W-1:0];
                end else begin
                    wb_vld_next = 1'b0;
                end
                if (wb_vld_reg) begin
                    mem_we       = 1'b1;
                    mem_waddr    = wb_idx_reg;
                    mem_wdata    = {rd_bc + mv, {CNT_W{1'b0}}};
                    cached_next  = cached_reg - SUM_W'(rd_cc);
                    written_next = written_reg + SUM_W'(mv);
                end else if (idx_reg == (CAT_W+1)'(MAX_CATEGORIES) && out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = {1'b0, ST_ROOM};
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, proc_reg, added_reg,
                                     written_reg, cached_reg, {ADDR_W{1'b0}}};
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            wb_vld_reg   <= 1'b0;
            cached_reg   <= '0;
            written_reg  <= '0;
            added_reg    <= '0;
            proc_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            wb_vld_reg   <= wb_vld_next;
            wb_idx_reg   <= wb_idx_next;
            req_reg      <= req_next;
            cat_reg      <= cat_next;
            cached_reg   <= cached_next;
            written_reg  <= written_next;
            added_reg    <= added_next;
            proc_reg     <= proc_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    `BSRC_ASSERT_SAME(a_slot_needs_room, m_tvalid && m_tuser[3], (m_tuser[2:0] == ST_ROOM || m_tuser[2:0] == ST_LAST), "slot reserved without room status")
    `BSRC_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken while one is in work")
    `BSRC_ASSERT_SAME(a_cache_bound, mem_we, mem_wdata[CNT_W-1:0] <= CNT_W'(MAX_CAPACITY), "cache count written above capacity")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for bucket_slot_reservation_counter: a directed request table, then random
// request phases under several capacity settings, every result checked against a predictor and the table.
// Depends on bsrc_pkg and the RTL of the block.
module tb_top;
    import bsrc_pkg::*;

    localparam int PHASE_ITEMS  = 241;
    localparam int N_PHASES     = 8;
    localparam int FLUSH_BUDGET = 90;
    localparam int HOLD_CYCLES  = 400;
    localparam int END_CYCLES   = 1100;
    localparam int CYCLE_LIMIT  = 4 * (1024 + 1960 * 48 + 100 * 1040 + HOLD_CYCLES
                                       + N_PHASES * 16 + END_CYCLES);

    typedef struct packed {
        logic [CNT_W-1:0]  backing;
        logic [CNT_W-1:0]  cache;
        logic [NCAT_W-1:0] ncat;
    } cap_setting_t;

    typedef struct packed {
        status_t           st;
        logic              vld;
        logic [ADDR_W-1:0] addr;
        logic [SUM_W-1:0]  cached;
        logic [SUM_W-1:0]  written;
        logic [SUM_W-1:0]  added;
        logic [PROC_W-1:0] processed;
    } slot_result_t;

    typedef struct packed {
        bit                is_cfg;
        cap_setting_t      caps;
        req_t              rq;
        logic [CAT_W-1:0]  cat;
        bit                typed;
        status_t           st;
        bit                vld;
        logic [ADDR_W-1:0] addr;
    } step_row_t;

    localparam int N_DIR = 27;
    localparam step_row_t DIR_ROWS [N_DIR] = '{
        // cfg caps                request     cat   typed status         vld  addr
        '{0, '{0, 0, 0},          REQ_ADD,    0,    1, ST_ROOM,       1, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    1023, 1, ST_ROOM,       1, 261888},
        '{0, '{0, 0, 0},          REQ_UNDO,   5,    1, ST_UNDO_EMPTY, 0, 0},
        '{0, '{0, 0, 0},          REQ_UNDO,   0,    1, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_NOP,    1023, 1, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_FLUSH,  0,    1, ST_ROOM,       0, 0},
        '{1, '{3, 2, 4},          REQ_NOP,    0,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    2,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    2,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    2,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_UNDO,   3,    1, ST_UNDO_EMPTY, 0, 0},
        '{0, '{0, 0, 0},          REQ_FLUSH,  0,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    2,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    2,    1, ST_CAT_FULL,   0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    4,    1, ST_BAD_CAT,    0, 0},
        '{0, '{0, 0, 0},          REQ_UNDO,   1023, 1, ST_BAD_CAT,    0, 0},
        '{1, '{2, 2, 4},          REQ_NOP,    0,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_FLUSH,  0,    0, ST_ROOM,       0, 0},
        '{1, '{0, 2, 4},          REQ_NOP,    0,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    1,    1, ST_CAT_FULL,   0, 0},
        '{1, '{0, 2, 0},          REQ_NOP,    0,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    0,    1, ST_BAD_CAT,    0, 0},
        '{1, '{8191, 8191, 2047}, REQ_NOP,    0,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    1023, 1, ST_ROOM,       1, 4190208},
        '{1, '{8191, 0, 2047},    REQ_NOP,    0,    0, ST_ROOM,       0, 0},
        '{0, '{0, 0, 0},          REQ_ADD,    7,    1, ST_LAST,       1, 7},
        '{0, '{0, 0, 0},          REQ_UNDO,   1023, 1, ST_ROOM,       0, 0}
    };

    localparam cap_setting_t PHASE_CAPS [N_PHASES-1] = '{
        '{8, 3, 16}, '{1, 1, 1024}, '{64, 8, 1000}, '{6, 9, 900},
        '{4096, 4096, 1}, '{8191, 0, 2047}, '{0, 5, 40}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [9:0] category, rest zero
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;   // [1:0] req_type
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [21:0] slot_address, [44:22] cached_total, [67:45] written_total,
    // [90:68] added_total, [122:91] processed_total, rest zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;         // [2:0] status, [3] slot_valid
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    bit   idle_on = 1'b0;
    bit   hold_go = 1'b0;
    logic hold_rx = 1'b0;
    int   fail_count = 0;

    logic [CNT_W-1:0]  cap_backing = RST_BACKING;
    logic [CNT_W-1:0]  cap_cache   = RST_CACHE;
    logic [NCAT_W-1:0] cap_ncat    = RST_NCAT;
    int unsigned       cache_fill   [MAX_CATEGORIES];
    int unsigned       backing_fill [MAX_CATEGORIES];
    logic [SUM_W-1:0]  cached_acc  = '0;
    logic [SUM_W-1:0]  written_acc = '0;
    logic [SUM_W-1:0]  added_acc   = '0;
    logic [PROC_W-1:0] request_acc = '0;

    slot_result_t pending_results [$];

    bucket_slot_reservation_counter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned backing_limit();
        return (cap_backing > MAX_CAPACITY) ? MAX_CAPACITY : cap_backing;
    endfunction

    function automatic int unsigned cache_limit();
        int unsigned c;
        c = cap_cache;
        if (c > backing_limit()) c = backing_limit();
        if (c == 0) c = 1;
        return c;
    endfunction

    function automatic int unsigned active_categories();
        return (cap_ncat > MAX_CATEGORIES) ? MAX_CATEGORIES : cap_ncat;
    endfunction

    function automatic slot_result_t predict_request(input req_t rq,
                                                     input logic [CAT_W-1:0] cat);
        slot_result_t r;
        int unsigned  idx, cc, cap, lim, mv, space;
        bit           good;
        r     = '0;
        r.st  = ST_ROOM;
        idx   = cat;
        cap   = cache_limit();
        lim   = backing_limit();
        good  = idx < active_categories();
        case (rq)
            REQ_ADD: begin
                request_acc = request_acc + 1'b1;
                if (!good) begin
                    r.st = ST_BAD_CAT;
                end else begin
                    cc = cache_fill[idx];
                    if (cc + backing_fill[idx] >= lim) r.st = ST_CAT_FULL;
                    else if (cc < cap - 1) r.st = ST_ROOM;
                    else if (cc == cap - 1) r.st = ST_LAST;
                    else r.st = ST_CACHE_FULL;
                    if (r.st == ST_ROOM || r.st == ST_LAST) begin
                        r.vld = 1'b1;
                        r.addr = ADDR_W'(idx * cap + cc);
                        cache_fill[idx] = cc + 1;
                        cached_acc = cached_acc + 1'b1;
                        added_acc = added_acc + 1'b1;
                    end
                end
            end
            REQ_UNDO: begin
                if (!good) begin
                    r.st = ST_BAD_CAT;
                end else if (cache_fill[idx] == 0) begin
                    r.st = ST_UNDO_EMPTY;
                end else begin
                    cache_fill[idx] = cache_fill[idx] - 1;
                    cached_acc = cached_acc - 1'b1;
                    added_acc = added_acc - 1'b1;
                end
            end
            REQ_FLUSH: begin
                for (int i = 0; i < MAX_CATEGORIES; i++) begin
                    space = (backing_fill[i] >= lim) ? 0 : lim - backing_fill[i];
                    mv = (cache_fill[i] > space) ? space : cache_fill[i];
                    cached_acc = cached_acc - SUM_W'(cache_fill[i]);
                    written_acc = written_acc + SUM_W'(mv);
                    backing_fill[i] = backing_fill[i] + mv;
                    cache_fill[i] = 0;
                end
            end
            default: ;
        endcase
        r.cached    = cached_acc;
        r.written   = written_acc;
        r.added     = added_acc;
        r.processed = request_acc;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (idx)
            REG_BACKING: cap_backing = val[CNT_W-1:0];
            REG_CACHE:   cap_cache   = val[CNT_W-1:0];
            REG_NCAT:    cap_ncat    = val[NCAT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_cfg(input cap_setting_t caps);
        apb_write(REG_BACKING, PDATA_W'(caps.backing));
        apb_write(REG_CACHE, PDATA_W'(caps.cache));
        apb_write(REG_NCAT, PDATA_W'(caps.ncat));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_req(input req_t rq, input logic [CAT_W-1:0] cat, input bit typed,
                            input status_t st, input bit vld,
                            input logic [ADDR_W-1:0] addr);
        slot_result_t res;
        if (idle_on && $urandom_range(0, 11) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= IN_TDATA_W'(cat);
        do @(posedge aclk); while (s_tready !== 1'b1);
        res = predict_request(rq, cat);
        if (typed) begin
            res.st   = st;
            res.vld  = vld;
            res.addr = addr;
        end
        pending_results.push_back(res);
    endtask

    always @(posedge aclk) begin : result_sink
        slot_result_t want;
        logic         ready_next;
        int           stall_left;
        if (m_tvalid === 1'b1 && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request pending, expected none actual status %0d",
                         $time, m_tuser[2:0]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 32'(want.st), 32'(m_tuser[2:0]));
                compare_field("slot_valid", 32'(want.vld), 32'(m_tuser[3]));
                compare_field("slot_address", 32'(want.addr), 32'(m_tdata[21:0]));
                compare_field("cached_total", 32'(want.cached), 32'(m_tdata[44:22]));
                compare_field("written_total", 32'(want.written), 32'(m_tdata[67:45]));
                compare_field("added_total", 32'(want.added), 32'(m_tdata[90:68]));
                compare_field("processed_total", want.processed, m_tdata[122:91]);
            end
        end
        ready_next = 1'b1;
        if (!aresetn || hold_rx) begin
            ready_next = 1'b0;
        end else if (stall_left > 0) begin
            ready_next = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            ready_next = 1'b0;
            stall_left = $urandom_range(0, 16);
        end
        m_tready <= ready_next;
    end

    // hold off the receiver while requests keep coming, so the block backs up
    initial begin : long_hold
        while (!hold_go) @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL bucket_slot_reservation_counter");
        $finish;
    end

    initial begin : stimulus
        cap_setting_t     caps;
        req_t             rq;
        logic [CAT_W-1:0] cat;
        int unsigned      base, top, pick, flushes_left;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].is_cfg) begin
                settle();
                write_cfg(DIR_ROWS[i].caps);
            end else begin
                send_req(DIR_ROWS[i].rq, DIR_ROWS[i].cat, DIR_ROWS[i].typed,
                         DIR_ROWS[i].st, DIR_ROWS[i].vld, DIR_ROWS[i].addr);
            end
        end

        flushes_left = FLUSH_BUDGET;
        base = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            if (ph < N_PHASES - 1) begin
                caps = PHASE_CAPS[ph];
            end else begin
                caps.backing = CNT_W'($urandom_range(1, 40));
                caps.cache   = CNT_W'($urandom_range(1, 12));
                caps.ncat    = NCAT_W'($urandom_range(1, 64));
            end
            write_cfg(caps);
            idle_on = (ph < N_PHASES - 1);
            if (ph == 1) hold_go = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // keep most requests on a small window of categories so counts build up
                top = (active_categories() > 8) ? active_categories() - 8 : 0;
                if (base > top || (k % 80 == 0 && $urandom_range(0, 1) == 1))
                    base = $urandom_range(0, top);
                pick = $urandom_range(0, 99);
                if (pick < 58) begin
                    rq = REQ_ADD;
                end else if (pick < 85) begin
                    rq = REQ_UNDO;
                end else if (pick < 89 && flushes_left > 0) begin
                    rq = REQ_FLUSH;
                    flushes_left--;
                end else begin
                    rq = REQ_NOP;
                end
                if ($urandom_range(0, 4) == 0)
                    cat = CAT_W'($urandom_range(0, MAX_CATEGORIES - 1));
                else
                    cat = CAT_W'(base + $urandom_range(0, 7));
                send_req(rq, cat, 1'b0, ST_ROOM, 1'b0, '0);
            end
        end

        settle();
        repeat (END_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS bucket_slot_reservation_counter");
        end else begin
            $display("FAIL bucket_slot_reservation_counter");
        end
        $finish;
    end

endmodule
